>>> sv/assert_macros.svh
// Assertion macros used by the token finder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ctf_pkg.sv
// Shared types, constants and helpers of the token finder.
package ctf_pkg;

    localparam int REG_TOKEN_CHARS     = 16;
    localparam int DEF_MAX_TOKEN_CHARS = 16;
    localparam int LEN_W               = 5;
    localparam int CFG_IDX_W           = 2;
    localparam int CFG_DATA_W          = 64;

    localparam logic [CFG_IDX_W-1:0] REG_TOKEN_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOKEN_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOKEN_LEN  = 2'd2;

    typedef struct packed {
        logic narrow_eq;
        logic wide_eq;
        logic is_zero;
    } cell_flags_t;

    // ASCII A..Z to lower case, all other bytes unchanged
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[8'h41:8'h5A]})
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

>>> sv/ctf_cell.sv
// One window cell: holds a byte and its presence flag, compares the incoming byte.
module ctf_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift_en,
    input  logic                clear,
    input  logic [7:0]          byte_in,
    input  logic                valid_in,
    input  logic [7:0]          cmp_narrow,
    input  logic [7:0]          cmp_wide,
    output logic [7:0]          byte_out,
    output logic                valid_out,
    output ctf_pkg::cell_flags_t flags
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] folded;

    assign folded = ctf_pkg::fold_case(byte_in);

    // flags describe the window after this cycle's shift
    assign flags.narrow_eq = valid_in && (folded == cmp_narrow);
    assign flags.wide_eq   = valid_in && (folded == cmp_wide);
    assign flags.is_zero   = valid_in && (byte_in == 8'h00);

    always_comb
    begin
        byte_next  = shift_en ? byte_in : byte_reg;
        valid_next = valid_reg;
        if (clear)
        begin
            valid_next = 1'b0;
        end
        else if (shift_en)
        begin
            valid_next = valid_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign byte_out  = byte_reg;
    assign valid_out = valid_reg;

endmodule

>>> sv/case_insensitive_token_finder_unit.sv
// Case-insensitive token finder: top level with token registers, cell chain and result stage.
// Takes one payload byte per cycle (in_valid/in_ready) while in_ready is high. Every byte
// shifts a chain of 2*MAX_TOKEN_CHARS cells; all cells compare in the same cycle against the
// token, both as 8-bit text and as UTF-16LE at any byte offset, so the byte that closes a
// match is judged in the cycle it is accepted. The request carrying last_byte loads one
// result into the output register and clears the window; a new byte is taken while that
// result waits, unless the result register is full and not being drained. ASCII A..Z are
// folded only. Configuration writes are accepted every cycle and act on the next byte;
// token_length (cfg_data[4:0]) above 16 or MAX_TOKEN_CHARS saturates, zero never matches.
`include "assert_macros.svh"

module case_insensitive_token_finder_unit #(
    parameter int MAX_TOKEN_CHARS = ctf_pkg::DEF_MAX_TOKEN_CHARS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       data_byte,
    input  logic                             last_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             found_narrow,
    output logic                             found_wide,
    output logic                             found_any,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ctf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ctf_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int WIN_DEPTH = 2 * MAX_TOKEN_CHARS;
    localparam int REG_CHARS = ctf_pkg::REG_TOKEN_CHARS;
    localparam int LEN_W     = ctf_pkg::LEN_W;
    localparam int LEN_CAP   = (MAX_TOKEN_CHARS < REG_CHARS) ? MAX_TOKEN_CHARS : REG_CHARS;

    logic [ctf_pkg::CFG_DATA_W-1:0] tok_low_reg, tok_low_next;
    logic [ctf_pkg::CFG_DATA_W-1:0] tok_high_reg, tok_high_next;
    logic [LEN_W-1:0]               tok_len_reg, tok_len_next;
    logic                           narrow_hit_reg, narrow_hit_next;
    logic                           wide_hit_reg, wide_hit_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           found_narrow_reg, found_narrow_next;
    logic                           found_wide_reg, found_wide_next;

    logic                           in_fire;
    logic                           cfg_fire;
    logic                           narrow_now;
    logic                           wide_now;
    logic [LEN_W-1:0]               act_len;
    logic [LEN_W-1:0]               rev_skip;
    logic [2*ctf_pkg::CFG_DATA_W-1:0] tok_all;
    logic [REG_CHARS*8-1:0]         tok_rev_vec;
    logic [REG_CHARS*8-1:0]         tok_rev_shift;
    logic [7:0]                     tok_rev [MAX_TOKEN_CHARS];
    logic [MAX_TOKEN_CHARS-1:0]     narrow_ok;
    logic [MAX_TOKEN_CHARS-1:0]     wide_ok;

    logic [7:0]                     win_byte  [WIN_DEPTH];
    logic                           win_valid [WIN_DEPTH];
    ctf_pkg::cell_flags_t           flags     [WIN_DEPTH];

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;

    // ---- token registers ----
    always_comb
    begin
        tok_low_next  = tok_low_reg;
        tok_high_next = tok_high_reg;
        tok_len_next  = tok_len_reg;
        if (cfg_fire)
        begin
            case (cfg_index)
                ctf_pkg::REG_TOKEN_LOW:  tok_low_next  = cfg_data;
                ctf_pkg::REG_TOKEN_HIGH: tok_high_next = cfg_data;
                ctf_pkg::REG_TOKEN_LEN:  tok_len_next  = cfg_data[LEN_W-1:0];
                default:                 tok_len_next  = tok_len_reg;
            endcase
        end
    end

    assign act_len = (tok_len_reg > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : tok_len_reg;

    // reversed folded token, right-aligned so that entry j is token char len-1-j
    assign tok_all  = {tok_high_reg, tok_low_reg};
    assign rev_skip = LEN_W'(REG_CHARS) - act_len;

    always_comb
    begin
        for (int i = 0; i < REG_CHARS; i++)
        begin
            tok_rev_vec[8*i +: 8] = ctf_pkg::fold_case(tok_all[8*(REG_CHARS-1-i) +: 8]);
        end
    end

    assign tok_rev_shift = tok_rev_vec >> {rev_skip, 3'b000};

    genvar m;
    generate
        for (m = 0; m < MAX_TOKEN_CHARS; m++)
        begin : g_rev
            if (m < REG_CHARS)
            begin : g_in
                assign tok_rev[m] = tok_rev_shift[8*m +: 8];
            end
            else
            begin : g_out
                assign tok_rev[m] = 8'h00;
            end
        end
    endgenerate

    // ---- cell chain, newest byte in cell 0 ----
    genvar j;
    generate
        for (j = 0; j < WIN_DEPTH; j++)
        begin : g_cell
            logic [7:0] byte_in;
            logic       valid_in;
            logic [7:0] cmp_narrow;
            logic [7:0] cmp_wide;

            if (j == 0)
            begin : g_head
                assign byte_in  = data_byte;
                assign valid_in = 1'b1;
            end
            else
            begin : g_link
                assign byte_in  = win_byte[j-1];
                assign valid_in = win_valid[j-1];
            end

            if (j < MAX_TOKEN_CHARS)
            begin : g_cn
                assign cmp_narrow = tok_rev[j];
            end
            else
            begin : g_nn
                assign cmp_narrow = 8'h00;
            end

            // odd cells hold the low byte of a wide character
            if ((j % 2) == 1)
            begin : g_cw
                assign cmp_wide = tok_rev[j/2];
            end
            else
            begin : g_nw
                assign cmp_wide = 8'h00;
            end

            ctf_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .shift_en   (in_fire),
                .clear      (in_fire && last_byte),
                .byte_in    (byte_in),
                .valid_in   (valid_in),
                .cmp_narrow (cmp_narrow),
                .cmp_wide   (cmp_wide),
                .byte_out   (win_byte[j]),
                .valid_out  (win_valid[j]),
                .flags      (flags[j])
            );
        end

        for (m = 0; m < MAX_TOKEN_CHARS; m++)
        begin : g_match
            logic beyond;
            assign beyond       = (6'(m) >= {1'b0, act_len});
            assign narrow_ok[m] = beyond || flags[m].narrow_eq;
            assign wide_ok[m]   = beyond || (flags[2*m].is_zero && flags[2*m+1].wide_eq);
        end
    endgenerate

    assign narrow_now = (act_len != '0) && (&narrow_ok);
    assign wide_now   = (act_len != '0) && (&wide_ok);

    // ---- sticky hits and result stage ----
    always_comb
    begin
        narrow_hit_next   = narrow_hit_reg;
        wide_hit_next     = wide_hit_reg;
        out_valid_next    = out_valid_reg;
        found_narrow_next = found_narrow_reg;
        found_wide_next   = found_wide_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (in_fire)
        begin
            if (last_byte)
            begin
                narrow_hit_next   = 1'b0;
                wide_hit_next     = 1'b0;
                out_valid_next    = 1'b1;
                found_narrow_next = narrow_hit_reg || narrow_now;
                found_wide_next   = wide_hit_reg || wide_now;
            end
            else
            begin
                narrow_hit_next = narrow_hit_reg || narrow_now;
                wide_hit_next   = wide_hit_reg || wide_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_low_reg    <= '0;
            tok_high_reg   <= '0;
            tok_len_reg    <= '0;
            narrow_hit_reg <= 1'b0;
            wide_hit_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            tok_low_reg    <= tok_low_next;
            tok_high_reg   <= tok_high_next;
            tok_len_reg    <= tok_len_next;
            narrow_hit_reg <= narrow_hit_next;
            wide_hit_reg   <= wide_hit_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_narrow_reg <= found_narrow_next;
        found_wide_reg   <= found_wide_next;
    end

    assign out_valid    = out_valid_reg;
    assign found_narrow = found_narrow_reg;
    assign found_wide   = found_wide_reg;
    assign found_any    = found_narrow_reg || found_wide_reg;

    // ---- checks ----
    `ASSERT_NEXT(a_last_gives_result, in_fire && last_byte, out_valid, "last byte gave no result")
    `ASSERT_NEXT(a_last_clears_hits, in_fire && last_byte,
                 !narrow_hit_reg && !wide_hit_reg, "hits not cleared after payload end")
    `ASSERT_IMPL(a_full_blocks_input, out_valid && !out_ready, !in_ready,
                 "input taken while result stalled")
    `ASSERT_NEXT(a_empty_never_hits,
                 in_fire && last_byte && (tok_len_reg == '0) && !narrow_hit_reg && !wide_hit_reg,
                 !found_any, "empty token reported a match")

endmodule
